>>> hw/rtl/slps_pkg.sv
// shared types, codes and helpers for the status led pattern sequencer
package slps_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int NUM_REGS   = 7;
    localparam int CFG_IDX_W  = 3;

    typedef logic [1:0]            mode_t;
    typedef logic [2:0]            dev_state_t;
    typedef logic [2:0]            pattern_t;
    typedef logic [1:0]            phase_t;
    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [CFG_W-1:0]      cfg_word_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

    localparam mode_t MODE_TICK  = 2'd0;
    localparam mode_t MODE_SET   = 2'd1;
    localparam mode_t MODE_ERROR = 2'd2;
    localparam mode_t MODE_FAST  = 2'd3;

    localparam dev_state_t ST_BOOT      = 3'd0;
    localparam dev_state_t ST_IDLE      = 3'd1;
    localparam dev_state_t ST_CALIBRATE = 3'd2;
    localparam dev_state_t ST_SESSION   = 3'd3;
    localparam dev_state_t ST_ERROR     = 3'd4;

    localparam pattern_t PAT_OFF    = 3'd0;
    localparam pattern_t PAT_SOLID  = 3'd1;
    localparam pattern_t PAT_FAST   = 3'd2;
    localparam pattern_t PAT_SLOW   = 3'd3;
    localparam pattern_t PAT_PULSE  = 3'd4;
    localparam pattern_t PAT_DOUBLE = 3'd5;

    // double flash steps
    localparam phase_t FL_LEAD   = 2'd0;
    localparam phase_t FL_FIRST  = 2'd1;
    localparam phase_t FL_GAP    = 2'd2;
    localparam phase_t FL_SECOND = 2'd3;

    localparam cfg_idx_t REG_FAST_HALF   = 3'd0;
    localparam cfg_idx_t REG_SLOW_HALF   = 3'd1;
    localparam cfg_idx_t REG_PULSE_HALF  = 3'd2;
    localparam cfg_idx_t REG_FLASH_ON    = 3'd3;
    localparam cfg_idx_t REG_FLASH_GAP   = 3'd4;
    localparam cfg_idx_t REG_ERROR_PAUSE = 3'd5;
    localparam cfg_idx_t REG_ERROR_START = 3'd6;

    localparam cfg_word_t CFG_RESET [NUM_REGS] = '{
        16'd100, 16'd300, 16'd1000, 16'd150, 16'd400, 16'd2000, 16'd100
    };

    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    // zero becomes one, anything above the countdown range saturates
    function automatic timer_t arm_delay(input cfg_word_t d);
        logic [32:0] w;
        w = {{(33-CFG_W){1'b0}}, d};
        if (w == 33'd0)
        begin
            w = 33'd1;
        end
        if (w > TIMER_MAX)
        begin
            w = TIMER_MAX;
        end
        return w[TIMER_BITS-1:0];
    endfunction

    function automatic pattern_t state_pattern(input dev_state_t s);
        pattern_t p;
        unique case (s) inside
            ST_BOOT, ST_CALIBRATE: p = PAT_FAST;
            ST_IDLE:               p = PAT_PULSE;
            ST_SESSION:            p = PAT_SOLID;
            ST_ERROR:              p = PAT_DOUBLE;
            default:               p = PAT_OFF;
        endcase
        return p;
    endfunction

endpackage

>>> hw/rtl/status_led_pattern_sequencer.sv
// status led pattern sequencer: input register, state update and result register
// path: input register, then state update, then result register, which raises out_valid
// throughput: one transaction per cycle unless out_stall holds a result; the update is
//   a single pass of narrow logic between the input register and the result register
// reset: stored state boot, fast blink armed at 100 ms, led dark, config registers
//   at their defaults, no transactions in flight
module status_led_pattern_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  slps_pkg::mode_t      mode,
    input  slps_pkg::dev_state_t new_state,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 led_on,
    output slps_pkg::pattern_t   pattern,
    input  logic                 cfg_write_en,
    input  slps_pkg::cfg_idx_t   cfg_index,
    input  slps_pkg::cfg_word_t  cfg_data
);
    import slps_pkg::*;

    cfg_word_t  cfg_reg [NUM_REGS];

    logic       s1_valid_reg;
    mode_t      s1_mode_reg;
    dev_state_t s1_state_reg;

    dev_state_t stored_state_reg, stored_state_next;
    pattern_t   active_pattern_reg, active_pattern_next;
    phase_t     flash_phase_reg, flash_phase_next;
    logic       led_level_reg, led_level_next;
    timer_t     countdown_reg, countdown_next;
    logic       timer_armed_reg, timer_armed_next;

    logic       out_valid_reg;
    logic       out_led_reg;
    pattern_t   out_pattern_reg;

    logic       advance;
    logic       do_start;
    pattern_t   start_pat;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    // configuration registers, out-of-range index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_write_en && (int'(cfg_index) < NUM_REGS))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_mode_reg  <= mode;
            s1_state_reg <= new_state;
        end
    end

    // sequencer update for the transaction in the input register
    always_comb
    begin
        stored_state_next   = stored_state_reg;
        active_pattern_next = active_pattern_reg;
        flash_phase_next    = flash_phase_reg;
        led_level_next      = led_level_reg;
        countdown_next      = countdown_reg;
        timer_armed_next    = timer_armed_reg;
        do_start            = 1'b0;
        start_pat           = PAT_OFF;

        unique case (s1_mode_reg)
            MODE_TICK:
            begin
                if (timer_armed_reg)
                begin
                    if (countdown_reg <= timer_t'(1))
                    begin
                        countdown_next   = '0;
                        timer_armed_next = 1'b0;
                        case (active_pattern_reg)
                            PAT_SOLID:
                            begin
                                led_level_next = 1'b1;
                            end
                            PAT_FAST:
                            begin
                                led_level_next   = !led_level_reg;
                                countdown_next   = arm_delay(cfg_reg[REG_FAST_HALF]);
                                timer_armed_next = 1'b1;
                            end
                            PAT_SLOW:
                            begin
                                led_level_next   = !led_level_reg;
                                countdown_next   = arm_delay(cfg_reg[REG_SLOW_HALF]);
                                timer_armed_next = 1'b1;
                            end
                            PAT_PULSE:
                            begin
                                led_level_next   = !led_level_reg;
                                countdown_next   = arm_delay(cfg_reg[REG_PULSE_HALF]);
                                timer_armed_next = 1'b1;
                            end
                            PAT_DOUBLE:
                            begin
                                timer_armed_next = 1'b1;
                                flash_phase_next = flash_phase_reg + phase_t'(1);
                                case (flash_phase_reg) inside
                                    FL_LEAD, FL_GAP:
                                    begin
                                        led_level_next = 1'b1;
                                        countdown_next = arm_delay(cfg_reg[REG_FLASH_ON]);
                                    end
                                    FL_FIRST:
                                    begin
                                        led_level_next = 1'b0;
                                        countdown_next = arm_delay(cfg_reg[REG_FLASH_GAP]);
                                    end
                                    default:
                                    begin
                                        led_level_next = 1'b0;
                                        countdown_next = arm_delay(cfg_reg[REG_ERROR_PAUSE]);
                                    end
                                endcase
                            end
                            default:
                            begin
                                led_level_next = 1'b0;
                            end
                        endcase
                    end
                    else
                    begin
                        countdown_next = countdown_reg - timer_t'(1);
                    end
                end
            end
            MODE_SET:
            begin
                if (s1_state_reg != stored_state_reg)
                begin
                    stored_state_next = s1_state_reg;
                    do_start          = 1'b1;
                    start_pat         = state_pattern(s1_state_reg);
                end
            end
            MODE_ERROR:
            begin
                stored_state_next = ST_ERROR;
                do_start          = 1'b1;
                start_pat         = PAT_DOUBLE;
            end
            default:
            begin
                do_start  = 1'b1;
                start_pat = PAT_FAST;
            end
        endcase

        // every pattern starts from the first flash phase, and dark except solid
        if (do_start)
        begin
            active_pattern_next = start_pat;
            flash_phase_next    = FL_LEAD;
            led_level_next      = 1'b0;
            timer_armed_next    = 1'b1;
            case (start_pat)
                PAT_SOLID:
                begin
                    led_level_next   = 1'b1;
                    timer_armed_next = 1'b0;
                end
                PAT_FAST:   countdown_next = arm_delay(cfg_reg[REG_FAST_HALF]);
                PAT_SLOW:   countdown_next = arm_delay(cfg_reg[REG_SLOW_HALF]);
                PAT_PULSE:  countdown_next = arm_delay(cfg_reg[REG_PULSE_HALF]);
                PAT_DOUBLE: countdown_next = arm_delay(cfg_reg[REG_ERROR_START]);
                default:
                begin
                    active_pattern_next = PAT_OFF;
                    timer_armed_next    = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_state_reg   <= ST_BOOT;
            active_pattern_reg <= PAT_FAST;
            flash_phase_reg    <= FL_LEAD;
            led_level_reg      <= 1'b0;
            countdown_reg      <= arm_delay(CFG_RESET[REG_FAST_HALF]);
            timer_armed_reg    <= 1'b1;
        end
        else if (advance)
        begin
            stored_state_reg   <= stored_state_next;
            active_pattern_reg <= active_pattern_next;
            flash_phase_reg    <= flash_phase_next;
            led_level_reg      <= led_level_next;
            countdown_reg      <= countdown_next;
            timer_armed_reg    <= timer_armed_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_led_reg     <= led_level_next;
            out_pattern_reg <= active_pattern_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign led_on    = out_led_reg;
    assign pattern   = out_pattern_reg;

    // solid and off never run the timer
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_pattern_reg == PAT_SOLID || active_pattern_reg == PAT_OFF)
        |-> !timer_armed_reg)
        else $error("timer armed in a static pattern");

    // an armed countdown never sits at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        timer_armed_reg |-> (countdown_reg != '0))
        else $error("armed countdown at zero");

    // a transaction leaving the input register shows up as a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after update");

    // solid pattern always lights the led
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_pattern_reg == PAT_SOLID) |-> led_level_reg)
        else $error("solid pattern with led dark");

endmodule

>>> verif/status_led_pattern_sequencer_tb.sv
// self-checking testbench for the status led pattern sequencer: predictor, driver and monitor
`timescale 1ns / 100ps

module status_led_pattern_sequencer_tb;
    import slps_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE_CYCLS = 6;
    localparam int RAND_PHASES  = 9;
    localparam int PHASE_CMDS   = 120;
    localparam int MAX_REPORTS  = 30;

    // register index beyond the implemented set, writes to it are dropped
    localparam cfg_idx_t REG_UNUSED = 3'd7;

    typedef enum int { CFG_ALL_MAX, CFG_ALL_ZERO, CFG_ALL_ONE, CFG_MIXED } cfg_kind_e;
    typedef enum int { WAIT_NONE, WAIT_LIGHT, WAIT_HEAVY } wait_style_e;

    typedef struct packed {
        mode_t      mode;
        dev_state_t dev_state;
    } led_cmd_t;

    typedef struct packed {
        logic     led;
        pattern_t pattern;
    } led_view_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    mode_t      mode = MODE_TICK;
    dev_state_t new_state = ST_BOOT;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       led_on;
    pattern_t   pattern;
    logic       cfg_write_en = 1'b0;
    cfg_idx_t   cfg_index = REG_FAST_HALF;
    cfg_word_t  cfg_data = '0;

    status_led_pattern_sequencer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .new_state    (new_state),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .led_on       (led_on),
        .pattern      (pattern),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted sequencer state
    cfg_word_t  cfg_model [NUM_REGS];
    dev_state_t cur_state;
    pattern_t   cur_pattern;
    phase_t     cur_phase;
    logic       cur_level;
    timer_t     cur_count;
    logic       cur_armed;

    led_cmd_t    pending_cmds [$];
    led_view_t   led_expected [$];
    wait_style_e in_style  = WAIT_LIGHT;
    wait_style_e out_style = WAIT_LIGHT;
    logic        in_accepted = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          items_queued = 0;
    int          items_accepted = 0;
    int          results_checked = 0;
    int          timer_expiries = 0;
    int          settings_used = 0;
    int          errors = 0;

    function automatic int draw_wait(wait_style_e style);
        if (style == WAIT_NONE)
        begin
            return 0;
        end
        if (style == WAIT_LIGHT)
        begin
            return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // zero counts as one millisecond, anything beyond the countdown saturates
    function automatic void arm_timer(cfg_word_t delay_ms);
        longint unsigned w;
        longint unsigned lim;
        w = delay_ms;
        lim = (64'd1 << TIMER_BITS) - 64'd1;
        if (w == 0)
        begin
            w = 1;
        end
        if (w > lim)
        begin
            w = lim;
        end
        cur_count = timer_t'(w);
        cur_armed = 1'b1;
    endfunction

    function automatic void start_pattern(pattern_t p);
        cur_pattern = p;
        cur_phase = FL_LEAD;
        case (p)
            PAT_SOLID:
            begin
                cur_armed = 1'b0;
                cur_level = 1'b1;
            end
            PAT_FAST:
            begin
                cur_level = 1'b0;
                arm_timer(cfg_model[REG_FAST_HALF]);
            end
            PAT_SLOW:
            begin
                cur_level = 1'b0;
                arm_timer(cfg_model[REG_SLOW_HALF]);
            end
            PAT_PULSE:
            begin
                cur_level = 1'b0;
                arm_timer(cfg_model[REG_PULSE_HALF]);
            end
            PAT_DOUBLE:
            begin
                cur_level = 1'b0;
                arm_timer(cfg_model[REG_ERROR_START]);
            end
            default:
            begin
                cur_armed = 1'b0;
                cur_level = 1'b0;
                cur_pattern = PAT_OFF;
            end
        endcase
    endfunction

    function automatic void enter_state(dev_state_t s);
        case (s) inside
            ST_BOOT, ST_CALIBRATE: start_pattern(PAT_FAST);
            ST_IDLE:               start_pattern(PAT_PULSE);
            ST_SESSION:            start_pattern(PAT_SOLID);
            ST_ERROR:              start_pattern(PAT_DOUBLE);
            default:               start_pattern(PAT_OFF);
        endcase
    endfunction

    function automatic void timer_expired();
        timer_expiries++;
        case (cur_pattern)
            PAT_SOLID:
            begin
                cur_level = 1'b1;
                cur_armed = 1'b0;
            end
            PAT_FAST:
            begin
                cur_level = ~cur_level;
                arm_timer(cfg_model[REG_FAST_HALF]);
            end
            PAT_SLOW:
            begin
                cur_level = ~cur_level;
                arm_timer(cfg_model[REG_SLOW_HALF]);
            end
            PAT_PULSE:
            begin
                cur_level = ~cur_level;
                arm_timer(cfg_model[REG_PULSE_HALF]);
            end
            PAT_DOUBLE:
            begin
                case (cur_phase)
                    FL_LEAD:
                    begin
                        cur_level = 1'b1;
                        cur_phase = FL_FIRST;
                        arm_timer(cfg_model[REG_FLASH_ON]);
                    end
                    FL_FIRST:
                    begin
                        cur_level = 1'b0;
                        cur_phase = FL_GAP;
                        arm_timer(cfg_model[REG_FLASH_GAP]);
                    end
                    FL_GAP:
                    begin
                        cur_level = 1'b1;
                        cur_phase = FL_SECOND;
                        arm_timer(cfg_model[REG_FLASH_ON]);
                    end
                    default:
                    begin
                        cur_level = 1'b0;
                        cur_phase = FL_LEAD;
                        arm_timer(cfg_model[REG_ERROR_PAUSE]);
                    end
                endcase
            end
            default:
            begin
                cur_level = 1'b0;
                cur_armed = 1'b0;
            end
        endcase
    endfunction

    function automatic led_view_t led_predict(led_cmd_t c);
        led_view_t v;
        case (c.mode)
            MODE_TICK:
            begin
                if (cur_armed)
                begin
                    if (cur_count <= timer_t'(1))
                    begin
                        cur_count = '0;
                        cur_armed = 1'b0;
                        timer_expired();
                    end
                    else
                    begin
                        cur_count = cur_count - timer_t'(1);
                    end
                end
            end
            MODE_SET:
            begin
                // same state again leaves everything alone
                if (c.dev_state != cur_state)
                begin
                    cur_state = c.dev_state;
                    enter_state(c.dev_state);
                end
            end
            MODE_ERROR:
            begin
                cur_state = ST_ERROR;
                enter_state(ST_ERROR);
            end
            MODE_FAST:
            begin
                start_pattern(PAT_FAST);
            end
            default:
            begin
            end
        endcase
        v.led = cur_level;
        v.pattern = cur_pattern;
        return v;
    endfunction

    // input driver
    always @(negedge clk)
    begin : cmd_driver
        led_cmd_t c;
        if (rst_n && !(in_valid && !in_accepted))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_cmds.size() > 0)
            begin
                c = pending_cmds.pop_front();
                mode <= c.mode;
                new_state <= c.dev_state;
                in_valid <= 1'b1;
                gap_left = draw_wait(in_style);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin : stall_driver
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // monitor: register writes, input transactions and result checking
    always @(posedge clk)
    begin : led_monitor
        led_cmd_t  c;
        led_view_t want;
        if (rst_n)
        begin
            if (cfg_write_en && cfg_index < NUM_REGS)
            begin
                cfg_model[cfg_index] = cfg_data;
            end
            in_accepted = in_valid && !in_stall;
            if (in_accepted)
            begin
                c.mode = mode;
                c.dev_state = new_state;
                led_expected.push_back(led_predict(c));
                items_accepted++;
            end
            if (out_valid && !out_stall)
            begin
                results_checked++;
                stall_left = draw_wait(out_style);
                if (led_expected.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        $display("%0t: unexpected result led_on=%0b pattern=%0d",
                                 $time, led_on, pattern);
                    end
                end
                else
                begin
                    want = led_expected.pop_front();
                    if (led_on !== want.led)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("%0t: led_on expected %0b actual %0b (result %0d)",
                                     $time, want.led, led_on, results_checked);
                        end
                    end
                    if (pattern !== want.pattern)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("%0t: pattern expected %0d actual %0d (result %0d)",
                                     $time, want.pattern, pattern, results_checked);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("status_led_pattern_sequencer_tb: done, errors");
                $finish;
            end
        end
    end

    task automatic queue_cmd(mode_t m, dev_state_t s);
        led_cmd_t c;
        c.mode = m;
        c.dev_state = s;
        pending_cmds.push_back(c);
        items_queued++;
    endtask

    task automatic queue_random_cmd();
        int r;
        r = $urandom_range(0, 99);
        // mostly ticks so that the countdowns actually run out
        if (r < 70)
        begin
            queue_cmd(MODE_TICK, dev_state_t'($urandom_range(0, 7)));
        end
        else if (r < 86)
        begin
            queue_cmd(MODE_SET, dev_state_t'($urandom_range(0, 7)));
        end
        else if (r < 93)
        begin
            queue_cmd(MODE_ERROR, dev_state_t'($urandom_range(0, 7)));
        end
        else
        begin
            queue_cmd(MODE_FAST, dev_state_t'($urandom_range(0, 7)));
        end
    endtask

    task automatic wait_drained();
        while (results_checked < items_queued)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLS) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, cfg_word_t val);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_write_en <= 1'b0;
        settings_used++;
    endtask

    function automatic cfg_word_t pick_setting(cfg_kind_e kind);
        int r;
        case (kind)
            CFG_ALL_MAX:  return '1;
            CFG_ALL_ZERO: return '0;
            CFG_ALL_ONE:  return cfg_word_t'(1);
            default:
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                begin
                    return '0;
                end
                if (r == 1)
                begin
                    return cfg_word_t'($urandom_range(7, 300));
                end
                return cfg_word_t'($urandom_range(1, 6));
            end
        endcase
    endfunction

    task automatic load_settings(cfg_kind_e kind);
        write_reg(REG_FAST_HALF, pick_setting(kind));
        write_reg(REG_SLOW_HALF, pick_setting(kind));
        write_reg(REG_PULSE_HALF, pick_setting(kind));
        write_reg(REG_FLASH_ON, pick_setting(kind));
        write_reg(REG_FLASH_GAP, pick_setting(kind));
        write_reg(REG_ERROR_PAUSE, pick_setting(kind));
        write_reg(REG_ERROR_START, pick_setting(kind));
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(REG_UNUSED, cfg_word_t'($urandom_range(0, 65535)));
        end
        end_writes();
    endtask

    initial
    begin : stimulus
        cfg_kind_e kind;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_model[i] = CFG_RESET[i];
        end
        cur_state = ST_BOOT;
        cur_level = 1'b0;
        cur_armed = 1'b0;
        start_pattern(PAT_FAST);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default settings: every state code, repeats and forced patterns
        queue_cmd(MODE_TICK, dev_state_t'(7));
        queue_cmd(MODE_SET, ST_BOOT);
        queue_cmd(MODE_SET, ST_SESSION);
        queue_cmd(MODE_TICK, ST_BOOT);
        queue_cmd(MODE_SET, dev_state_t'(5));
        queue_cmd(MODE_SET, dev_state_t'(6));
        queue_cmd(MODE_SET, dev_state_t'(7));
        queue_cmd(MODE_SET, ST_IDLE);
        queue_cmd(MODE_SET, ST_CALIBRATE);
        queue_cmd(MODE_ERROR, dev_state_t'(7));
        queue_cmd(MODE_ERROR, ST_BOOT);
        queue_cmd(MODE_FAST, dev_state_t'(5));
        // stored state is still error, so this one changes nothing
        queue_cmd(MODE_SET, ST_ERROR);
        wait_drained();

        // short delays, two of them zero, plus a write to a missing register
        write_reg(REG_FAST_HALF, cfg_word_t'(1));
        write_reg(REG_SLOW_HALF, '0);
        write_reg(REG_PULSE_HALF, cfg_word_t'(2));
        write_reg(REG_FLASH_ON, cfg_word_t'(1));
        write_reg(REG_FLASH_GAP, cfg_word_t'(2));
        write_reg(REG_ERROR_PAUSE, cfg_word_t'(1));
        write_reg(REG_ERROR_START, '0);
        write_reg(REG_UNUSED, '1);
        end_writes();
        queue_cmd(MODE_SET, ST_BOOT);
        queue_cmd(MODE_TICK, ST_BOOT);
        queue_cmd(MODE_TICK, ST_BOOT);
        queue_cmd(MODE_ERROR, ST_IDLE);
        repeat (7) queue_cmd(MODE_TICK, ST_BOOT);
        queue_cmd(MODE_SET, ST_SESSION);
        queue_cmd(MODE_TICK, ST_BOOT);
        queue_cmd(MODE_SET, ST_IDLE);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                kind = CFG_ALL_MAX;
            end
            else if (ph == 1)
            begin
                kind = CFG_ALL_ZERO;
            end
            else if (ph == 2)
            begin
                kind = CFG_ALL_ONE;
            end
            else
            begin
                kind = CFG_MIXED;
            end
            in_style = wait_style_e'(ph % 3);
            out_style = wait_style_e'((ph / 3) % 3);
            load_settings(kind);
            repeat (PHASE_CMDS) queue_random_cmd();
            wait_drained();
        end

        if (led_expected.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, led_expected.size());
        end
        $display("covered %0d commands over %0d register settings, %0d results checked",
                 items_accepted, settings_used, results_checked);
        $display("countdowns expired %0d times, %0d mismatches", timer_expiries, errors);
        if (errors == 0)
        begin
            $display("status_led_pattern_sequencer_tb: done, clean");
        end
        else
        begin
            $display("status_led_pattern_sequencer_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/slps_pkg.sv
hw/rtl/status_led_pattern_sequencer.sv
verif/status_led_pattern_sequencer_tb.sv
